/* rtl/core/zsmc_pkg.sv */
// Package with the shared types, codes and constants of the zone speed motion controller.
package zsmc_pkg;

  localparam int SpeedW   = 16;
  localparam int CountW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_AUTO      = 3'd1,
    OP_MANUAL    = 3'd2,
    OP_HOMING    = 3'd3,
    OP_SOFT_STOP = 3'd4,
    OP_STOP      = 3'd5
  } op_t;

  // Drive command codes of a result transaction.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SPEED = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_ESTOP = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ZONE_UNKNOWN    = 2'd0,
    ZONE_OPEN_SLOW  = 2'd1,
    ZONE_MAIN       = 2'd2,
    ZONE_CLOSE_SLOW = 2'd3
  } zone_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOW_SPEED     = 3'd0,
    REG_FAST_SPEED     = 3'd1,
    REG_MANUAL_SPEED   = 3'd2,
    REG_HOMING_SPEED   = 3'd3,
    REG_ENTRY_DELAY    = 3'd4,
    REG_ZONE_SWITCHES  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SpeedW-1:0] slow_speed;
    logic [SpeedW-1:0] fast_speed;
    logic [SpeedW-1:0] manual_speed;
    logic [SpeedW-1:0] homing_speed;
    logic [CountW-1:0] entry_delay_ms;
    logic              zone_switches_present;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    slow_speed:            16'd300,
    fast_speed:            16'd1500,
    manual_speed:          16'd800,
    homing_speed:          16'd300,
    entry_delay_ms:        16'd500,
    zone_switches_present: 1'b1
  };

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] direction;
    logic [1:0] zone;
    logic       approach_slowdown;
    logic       emergency;
    logic       driver_accepts;
  } item_t;

  typedef struct packed {
    logic [2:0]        drive_command;
    logic [1:0]        drive_direction;
    logic [SpeedW-1:0] drive_speed;
    logic              accepted;
    logic              auto_active;
    logic              slow_active;
  } result_t;

  typedef struct packed {
    dir_t              move_direction;
    zone_t             last_zone;
    logic              auto_move_flag;
    logic              slow_flag;
    logic [CountW-1:0] ms_count;
  } state_t;

  localparam state_t StateReset = '{
    move_direction: DIR_NONE,
    last_zone:      ZONE_UNKNOWN,
    auto_move_flag: 1'b0,
    slow_flag:      1'b0,
    ms_count:       '0
  };

endpackage

/* rtl/core/zsmc_ifs.sv */
// Channel interfaces of the zone speed motion controller: items, results and configuration.
interface zsmc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] direction;
  logic [1:0] zone;
  logic       approach_slowdown;
  logic       emergency;
  logic       driver_accepts;

  modport source (output valid, operation, direction, zone, approach_slowdown, emergency,
                  driver_accepts, input ready);
  modport sink   (input valid, operation, direction, zone, approach_slowdown, emergency,
                  driver_accepts, output ready);
endinterface

interface zsmc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  drive_command;
  logic [1:0]  drive_direction;
  logic [15:0] drive_speed;
  logic        accepted;
  logic        auto_active;
  logic        slow_active;

  modport source (output valid, drive_command, drive_direction, drive_speed, accepted,
                  auto_active, slow_active, input ready);
  modport sink   (input valid, drive_command, drive_direction, drive_speed, accepted,
                  auto_active, slow_active, output ready);
endinterface

interface zsmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/zsmc_cfg.sv */
// Configuration register file of the zone speed motion controller.
module zsmc_cfg
  import zsmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  zsmc_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Writes are taken in every cycle.
  assign cfg.ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CfgReset;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_SLOW_SPEED:    regs.slow_speed            <= cfg.data;
        REG_FAST_SPEED:    regs.fast_speed            <= cfg.data;
        REG_MANUAL_SPEED:  regs.manual_speed          <= cfg.data;
        REG_HOMING_SPEED:  regs.homing_speed          <= cfg.data;
        REG_ENTRY_DELAY:   regs.entry_delay_ms        <= cfg.data;
        REG_ZONE_SWITCHES: regs.zone_switches_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/zsmc_step.sv */
// Per-transaction decision logic: next controller state and the drive command to issue.
module zsmc_step
  import zsmc_pkg::*;
(
  input  cfg_t    regs,
  input  state_t  state,
  input  item_t   item,
  output state_t  state_next,
  output result_t res
);

  // Slow speed is wanted in an unknown zone, in the slow zone of the travel direction,
  // or always when the zone switches are absent.
  function automatic logic wants_slow(zone_t zone, dir_t dir, logic present);
    logic slow;
    slow = !present || (zone == ZONE_UNKNOWN) ||
           (zone == ZONE_OPEN_SLOW && dir == DIR_OPEN) ||
           (zone == ZONE_CLOSE_SLOW && dir == DIR_CLOSE);
    return slow;
  endfunction

  always_comb begin
    dir_t              dir;
    zone_t             zone;
    logic              want;
    logic              slow;
    logic [CountW-1:0] count_inc;

    // A direction code outside the list counts as none.
    case (item.direction)
      DIR_OPEN:  dir = DIR_OPEN;
      DIR_CLOSE: dir = DIR_CLOSE;
      default:   dir = DIR_NONE;
    endcase
    zone      = zone_t'(item.zone);
    count_inc = (state.ms_count == '1) ? state.ms_count : state.ms_count + 1'b1;
    want      = 1'b0;
    slow      = wants_slow(zone, dir, regs.zone_switches_present);

    state_next = state;
    res        = '0;

    case (op_t'(item.operation))
      OP_TICK: begin
        state_next.ms_count = count_inc;
        if (state.auto_move_flag) begin
          // A new zone restarts the entry delay.
          if (zone != state.last_zone) begin
            state_next.last_zone = zone;
            state_next.ms_count  = '0;
          end
          want = wants_slow(state_next.last_zone, state.move_direction,
                            regs.zone_switches_present) || item.approach_slowdown;
          if (want && !state.slow_flag) begin
            if (item.approach_slowdown || state_next.ms_count >= regs.entry_delay_ms) begin
              res.drive_command    = CMD_SPEED;
              res.drive_speed      = regs.slow_speed;
              state_next.slow_flag = 1'b1;
            end
          end else if (!want && state.slow_flag) begin
            res.drive_command    = CMD_SPEED;
            res.drive_speed      = regs.fast_speed;
            state_next.slow_flag = 1'b0;
          end
        end
      end
      OP_AUTO: begin
        res.drive_command   = CMD_START;
        res.drive_direction = dir;
        res.drive_speed     = slow ? regs.slow_speed : regs.fast_speed;
        res.accepted        = item.driver_accepts;
        if (item.driver_accepts) begin
          state_next.move_direction = dir;
          state_next.last_zone      = zone;
          state_next.auto_move_flag = 1'b1;
          state_next.slow_flag      = slow;
          state_next.ms_count       = '0;
        end
      end
      OP_MANUAL, OP_HOMING: begin
        res.drive_command   = CMD_START;
        res.drive_direction = dir;
        res.drive_speed     = (op_t'(item.operation) == OP_MANUAL) ? regs.manual_speed
                                                                    : regs.homing_speed;
        res.accepted        = item.driver_accepts;
        if (item.driver_accepts) begin
          state_next.move_direction = dir;
          state_next.auto_move_flag = 1'b0;
          state_next.slow_flag      = 1'b0;
        end
      end
      OP_SOFT_STOP: begin
        res.drive_command = CMD_SPEED;
        res.drive_speed   = regs.slow_speed;
      end
      OP_STOP: begin
        res.drive_command         = item.emergency ? CMD_ESTOP : CMD_STOP;
        res.accepted              = item.driver_accepts;
        state_next.move_direction = DIR_NONE;
        state_next.auto_move_flag = 1'b0;
        state_next.slow_flag      = 1'b0;
      end
      default: ;
    endcase

    res.auto_active = state_next.auto_move_flag;
    res.slow_active = state_next.slow_flag;
  end

endmodule

/* rtl/core/zone_speed_motion_controller.sv */
// Top level of the zone speed motion controller: input register, decision logic, result register.
// The block takes one transaction per clock cycle while the result side keeps up, and returns
// exactly one result transaction for each; a transaction passes through the input register and
// then the result register. The combinational decision logic between them updates the
// controller state as the transaction moves into the result register, so consecutive
// transactions see each other's effect with no gap. A stalled result holds its register and the
// input register still takes one more transaction. The configuration port is always ready, and
// its writes take effect on the next cycle.
module zone_speed_motion_controller
  import zsmc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  zsmc_item_if.sink     item,
  zsmc_result_if.source result,
  zsmc_cfg_if.sink      cfg
);

  cfg_t    regs;
  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  state;
  state_t  state_next;
  result_t res;
  logic    advance;

  zsmc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  zsmc_step u_step (
    .regs       (regs),
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .res        (res)
  );

  // The held transaction moves on when the result register is empty or being emptied.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item <= '{operation:         item.operation,
                   direction:         item.direction,
                   zone:              item.zone,
                   approach_slowdown: item.approach_slowdown,
                   emergency:         item.emergency,
                   driver_accepts:    item.driver_accepts};
    end
  end

  // Controller state follows each transaction as it is decided.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.drive_command   = out_res.drive_command;
  assign result.drive_direction = out_res.drive_direction;
  assign result.drive_speed     = out_res.drive_speed;
  assign result.accepted        = out_res.accepted;
  assign result.auto_active     = out_res.auto_active;
  assign result.slow_active     = out_res.slow_active;

`ifndef NO_ASSERTIONS
  // Slow speed is only ever applied during an automatic move.
  a_slow_needs_auto: assert property (@(posedge clk) disable iff (rst)
    state.slow_flag |-> state.auto_move_flag)
    else $error("slow flag set without an automatic move");

  // A result with no command carries no direction, speed or acceptance.
  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.drive_command == CMD_NONE) |->
      (out_res.drive_speed == '0) && (out_res.drive_direction == DIR_NONE) &&
      !out_res.accepted)
    else $error("empty command carries payload");

  // Controller state changes only when a transaction is decided.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a transaction");

  // Reported flags agree with each other.
  a_flags_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.slow_active |-> out_res.auto_active)
    else $error("slow reported without automatic move");
`endif

endmodule
